### hdl/sync_header_frame_deframer_assert.svh
// Assertion macros for the deframer RTL.
`ifndef SYNC_HEADER_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_HEADER_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define SHDF_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define SHDF_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/shdf_pkg.sv
// Types and constants shared by the sync header frame deframer.
`default_nettype none

package shdf_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;

  typedef enum logic [5:0] {
    PH_HUNT1  = 6'b000001,
    PH_HUNT2  = 6'b000010,
    PH_ADDR   = 6'b000100,
    PH_LEN_LO = 6'b001000,
    PH_LEN_HI = 6'b010000,
    PH_BODY   = 6'b100000
  } shdf_phase_t;

  typedef enum logic [3:0] {
    ST_IGNORED  = 4'd0,
    ST_HEADER   = 4'd1,
    ST_ADDR     = 4'd2,
    ST_LENGTH   = 4'd3,
    ST_BODY     = 4'd4,
    ST_DONE     = 4'd5,
    ST_TOO_LONG = 4'd6,
    ST_RESTART  = 4'd7,
    ST_RESYNCED = 4'd8
  } shdf_status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       resync;
  } shdf_in_t;

  typedef struct packed {
    shdf_status_t status;
    logic [7:0]   byte_out;
    logic [16:0]  frame_offset;
    logic [7:0]   frame_addr;
    logic [15:0]  frame_len;
  } shdf_out_t;

endpackage

`default_nettype wire

### hdl/shdf_parser.sv
// Frame parser: header hunt, address and length capture, body countdown.
`default_nettype none

module shdf_parser
  import shdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 256,
  parameter int CHECK_BYTES = 2
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          accept,
  input  shdf_in_t     item,
  output shdf_out_t    result,
  output shdf_phase_t  phase
);

  localparam logic [16:0] MaxLen    = 17'(MAX_PAYLOAD);
  localparam logic [16:0] CheckCnt  = 17'(CHECK_BYTES);

  shdf_phase_t  phase_r, phase_nxt;
  logic [16:0]  rem_r, rem_nxt;
  logic [16:0]  pos_r, pos_nxt;
  logic [7:0]   addr_r, addr_nxt;
  logic [15:0]  len_r, len_nxt;

  shdf_status_t status;
  logic [7:0]   echo;
  logic [16:0]  offs;
  logic [15:0]  len_full;
  logic [16:0]  rem_load;
  logic [16:0]  rem_dec;

  assign len_full = {item.rx_byte, len_r[7:0]};
  assign rem_load = {1'b0, len_full} + CheckCnt;
  assign rem_dec  = rem_r - 17'd1;

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    status    = ST_IGNORED;
    echo      = item.rx_byte;
    offs      = '0;
    if (item.resync) begin
      phase_nxt = PH_HUNT1;
      rem_nxt   = '0;
      pos_nxt   = '0;
      status    = ST_RESYNCED;
      echo      = '0;
    end else begin
      case (phase_r)
        PH_HUNT1: begin
          if (item.rx_byte == HDR_FIRST) begin
            status    = ST_HEADER;
            pos_nxt   = 17'd1;
            phase_nxt = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          rem_nxt = '0;
          if (item.rx_byte == HDR_SECOND) begin
            status    = ST_HEADER;
            offs      = 17'd1;
            pos_nxt   = 17'd2;
            phase_nxt = PH_ADDR;
          end else if (item.rx_byte == HDR_FIRST) begin
            // A repeated first header byte may itself open a new frame.
            status    = ST_RESTART;
            pos_nxt   = 17'd1;
            phase_nxt = PH_HUNT2;
          end else begin
            pos_nxt   = '0;
            phase_nxt = PH_HUNT1;
          end
        end
        PH_ADDR: begin
          status    = ST_ADDR;
          offs      = 17'd2;
          addr_nxt  = item.rx_byte;
          pos_nxt   = 17'd3;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          status    = ST_LENGTH;
          offs      = 17'd3;
          len_nxt   = {8'd0, item.rx_byte};
          pos_nxt   = 17'd4;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          offs    = 17'd4;
          len_nxt = len_full;
          if ({1'b0, len_full} > MaxLen) begin
            status    = ST_TOO_LONG;
            rem_nxt   = '0;
            pos_nxt   = '0;
            phase_nxt = PH_HUNT1;
          end else if (rem_load == 17'd0) begin
            // Empty frame with no check bytes ends on the length byte.
            status    = ST_DONE;
            rem_nxt   = '0;
            pos_nxt   = '0;
            phase_nxt = PH_HUNT1;
          end else begin
            status    = ST_LENGTH;
            rem_nxt   = rem_load;
            pos_nxt   = 17'd5;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          offs = pos_r;
          if (rem_dec == 17'd0) begin
            status    = ST_DONE;
            rem_nxt   = '0;
            pos_nxt   = '0;
            phase_nxt = PH_HUNT1;
          end else begin
            status  = ST_BODY;
            rem_nxt = rem_dec;
            pos_nxt = pos_r + 17'd1;
          end
        end
        default: begin
          rem_nxt   = '0;
          pos_nxt   = '0;
          phase_nxt = PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      rem_r   <= '0;
      pos_r   <= '0;
      addr_r  <= '0;
      len_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
    end
  end

  assign result.status       = status;
  assign result.byte_out     = echo;
  assign result.frame_offset = offs;
  assign result.frame_addr   = addr_nxt;
  assign result.frame_len    = len_nxt;
  assign phase               = phase_r;

endmodule

`default_nettype wire

### hdl/sync_header_frame_deframer.sv
// Top level of the sync header frame deframer.
`default_nettype none
`include "sync_header_frame_deframer_assert.svh"

// Byte-serial deframer for frames of the form 0xAA 0x55, address, length low,
// length high, then length payload bytes plus CHECK_BYTES checksum bytes. Each
// input transfer (one byte, or a resync marker for a receive overrun) yields
// exactly one result transfer carrying a status code, the echoed byte, its
// offset from the first header byte and the address and length latched for the
// current frame. Lengths above MAX_PAYLOAD drop the frame with a too-long status.
// The parser state advances in the cycle a byte is accepted and the result is
// registered, so one byte per cycle is sustained while the consumer keeps up.
// The output side is a two-entry register stage: a new byte is still accepted
// while one result waits on a stalled consumer, and in_stall rises only when
// both entries are full. Checksum verification and per-address dispatch are
// left to the logic downstream.
module sync_header_frame_deframer
  import shdf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 256,
  parameter int CHECK_BYTES = 2
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  shdf_in_t   in_data,
  output logic       out_valid,
  input  wire        out_stall,
  output shdf_out_t  out_data
);

  logic         in_accept;
  logic         out_pop;
  shdf_out_t    result;
  shdf_phase_t  phase;

  // Main output register and the skid entry behind it.
  logic         out_valid_r, out_valid_nxt;
  shdf_out_t    out_data_r, out_data_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  shdf_out_t    skid_data_r, skid_data_nxt;

  shdf_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .CHECK_BYTES (CHECK_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .result (result),
    .phase  (phase)
  );

  // The input stalls only while the skid entry holds a result, which is a
  // registered condition, so stall never depends combinationally on out_stall.
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_pop   = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (in_accept) begin
        out_data_nxt = result;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_r) begin
        // Consumer is holding the current result; park the new one.
        skid_data_nxt  = result;
        skid_valid_nxt = 1'b1;
      end else begin
        out_data_nxt  = result;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The skid entry only fills behind a waiting result.
  `SHDF_ASSERT_NOW(a_skid_behind_main, clk, rst_n, skid_valid_r, out_valid_r,
                   "skid entry holds a result while the output register is empty")

  // A resync always leaves the parser hunting for the first header byte.
  `SHDF_ASSERT_NEXT(a_resync_hunts, clk, rst_n, in_accept && in_data.resync,
                    phase == PH_HUNT1, "parser not hunting after resync")

  // A completed frame returns the parser to the header hunt.
  `SHDF_ASSERT_NEXT(a_done_hunts, clk, rst_n, in_accept && (result.status == ST_DONE),
                    phase == PH_HUNT1, "parser not hunting after frame done")

  // Every accepted byte leaves the output register holding a result next cycle, its own or an earlier one.
  `SHDF_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_accept, out_valid_r,
                    "accepted transfer left no result")

endmodule

`default_nettype wire
